// ===== design/mrss_pkg.sv =====
// Shared types and constants of the motor ramp/stop sequencer.
`default_nettype none

package mrss_pkg;

   // Widths fixed by the word fields and registers
   localparam int ELAPSED_W    = 32;
   localparam int RAMP_SHIFT   = 8;
   localparam int ELAPSED_HI_W = ELAPSED_W - RAMP_SHIFT;
   localparam int FAC_W        = 16;
   localparam int PROD_W       = ELAPSED_HI_W + FAC_W;
   localparam int MUL_STEPS    = ELAPSED_HI_W;
   localparam int DIV_STEPS    = PROD_W;
   localparam int STEP_CNT_W   = 6;
   localparam int SCAN_CNT_W   = 5;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // Option bits
   localparam int OPT_TEST_MODE     = 0;
   localparam int OPT_TIMEOUT_STOP  = 1;
   localparam int OPT_DISTANCE_STOP = 2;

   typedef enum logic [1:0] {
      PH_STOPPED  = 2'd0,
      PH_RAMP     = 2'd1,
      PH_TRANSIT  = 2'd2,
      PH_STOPPING = 2'd3
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_RATE      = 3'd0,
      CSR_CRUISE_DUTY     = 3'd1,
      CSR_STOP_DELAY_US   = 3'd2,
      CSR_TIMEOUT_US      = 3'd3,
      CSR_BATT_FLOOR      = 3'd4,
      CSR_DISTANCE_TARGET = 3'd5,
      CSR_OPTIONS         = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MATH,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_MUL,
      MS_DIV
   } math_state_type;

   typedef struct packed {
      logic        request_forward;
      logic        request_reverse;
      logic        at_track_start;
      logic        at_track_end;
      logic [9:0]  battery_level;
      logic [23:0] position_count;
   } req_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       forward;
      logic       drive_enable;
      phase_type  phase;
   } rsp_type;

   // Compare results of the serial scan
   typedef struct packed {
      logic ge_stop;
      logic ge_timeout;
      logic target_lt_pos;
      logic pos_lt_target;
      logic batt_under;
   } scan_flags_type;

   typedef struct packed {
      logic       sat;
      logic [7:0] duty;
   } ramp_result_type;

endpackage

`default_nettype wire

// ===== design/mrss_serial_scan.sv =====
// Bit-serial timer add and magnitude compares, LSB first, one bit per cycle.
`default_nettype none

module mrss_serial_scan #(
   parameter int TICK_US = 4080
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire  [mrss_pkg::ELAPSED_W-1:0]       elapsed,
   input  wire  [mrss_pkg::ELAPSED_W-1:0]       stop_delay_us,
   input  wire  [mrss_pkg::ELAPSED_W-1:0]       timeout_us,
   input  wire  [23:0]                          position_count,
   input  wire  [23:0]                          distance_target,
   input  wire  [9:0]                           battery_level,
   input  wire  [9:0]                           batt_floor,
   output logic                                 done,
   output logic [mrss_pkg::ELAPSED_W-1:0]       elapsed_new,
   output mrss_pkg::scan_flags_type             flags
);
   import mrss_pkg::*;

   localparam logic [ELAPSED_W-1:0] TICK = ELAPSED_W'(TICK_US);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SCAN_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  carry_ff, carry_in;
   logic [ELAPSED_W-1:0]  sum_ff, sum_in;
   // lt lanes: a < b so far, seen from the low end
   logic                  lt_stop_ff, lt_stop_in;
   logic                  lt_timeout_ff, lt_timeout_in;
   logic                  tgt_lt_pos_ff, tgt_lt_pos_in;
   logic                  pos_lt_tgt_ff, pos_lt_tgt_in;
   logic                  bat_low_ff, bat_low_in;

   logic [ELAPSED_W-1:0]  pos_ext, tgt_ext, bat_ext, low_ext;
   logic                  e_bit, t_bit, s_bit;

   function automatic logic lt_step(input logic a, input logic b, input logic lt);
      return (~a & b) | (~(a ^ b) & lt);
   endfunction

   assign pos_ext = ELAPSED_W'(position_count);
   assign tgt_ext = ELAPSED_W'(distance_target);
   assign bat_ext = ELAPSED_W'(battery_level);
   assign low_ext = ELAPSED_W'(batt_floor);

   assign e_bit = elapsed[cnt_ff];
   assign t_bit = TICK[cnt_ff];
   assign s_bit = e_bit ^ t_bit ^ carry_ff;

   always_comb begin
      busy_in       = busy_ff;
      done_in       = 1'b0;
      cnt_in        = cnt_ff;
      carry_in      = carry_ff;
      sum_in        = sum_ff;
      lt_stop_in    = lt_stop_ff;
      lt_timeout_in = lt_timeout_ff;
      tgt_lt_pos_in = tgt_lt_pos_ff;
      pos_lt_tgt_in = pos_lt_tgt_ff;
      bat_low_in    = bat_low_ff;
      if (start) begin
         busy_in       = 1'b1;
         cnt_in        = '0;
         carry_in      = 1'b0;
         lt_stop_in    = 1'b0;
         lt_timeout_in = 1'b0;
         tgt_lt_pos_in = 1'b0;
         pos_lt_tgt_in = 1'b0;
         bat_low_in    = 1'b0;
      end else if (busy_ff) begin
         carry_in      = (e_bit & t_bit) | (carry_ff & (e_bit ^ t_bit));
         sum_in        = {s_bit, sum_ff[ELAPSED_W-1:1]};
         lt_stop_in    = lt_step(s_bit, stop_delay_us[cnt_ff], lt_stop_ff);
         lt_timeout_in = lt_step(s_bit, timeout_us[cnt_ff], lt_timeout_ff);
         tgt_lt_pos_in = lt_step(tgt_ext[cnt_ff], pos_ext[cnt_ff], tgt_lt_pos_ff);
         pos_lt_tgt_in = lt_step(pos_ext[cnt_ff], tgt_ext[cnt_ff], pos_lt_tgt_ff);
         bat_low_in    = lt_step(bat_ext[cnt_ff], low_ext[cnt_ff], bat_low_ff);
         cnt_in        = cnt_ff + 1'b1;
         if (cnt_ff == SCAN_CNT_W'(ELAPSED_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff        <= cnt_in;
      carry_ff      <= carry_in;
      sum_ff        <= sum_in;
      lt_stop_ff    <= lt_stop_in;
      lt_timeout_ff <= lt_timeout_in;
      tgt_lt_pos_ff <= tgt_lt_pos_in;
      pos_lt_tgt_ff <= pos_lt_tgt_in;
      bat_low_ff    <= bat_low_in;
   end

   assign done                = done_ff;
   assign elapsed_new         = sum_ff;
   assign flags.ge_stop       = ~lt_stop_ff;
   assign flags.ge_timeout    = ~lt_timeout_ff;
   assign flags.target_lt_pos = tgt_lt_pos_ff;
   assign flags.pos_lt_target = pos_lt_tgt_ff;
   assign flags.batt_under    = bat_low_ff;

endmodule

`default_nettype wire

// ===== design/mrss_ramp_math.sv =====
// Ramp duty: shift-add multiply then restoring divide, one bit per cycle.
`default_nettype none

module mrss_ramp_math #(
   parameter int RAMP_DIVISOR = 390625
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [mrss_pkg::ELAPSED_W-1:0]  elapsed_new,
   input  wire  [7:0]                      accel_rate,
   input  wire  [7:0]                      cruise_duty,
   output logic                            done,
   output mrss_pkg::ramp_result_type       result
);
   import mrss_pkg::*;

   localparam int REM_W = $clog2(RAMP_DIVISOR + 1);
   localparam int DIV_W = REM_W + 1;
   localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(RAMP_DIVISOR);

   math_state_type        state_ff, state_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FAC_W-1:0]      fac_ff, fac_in;
   logic [PROD_W-1:0]     p_ff, p_in;     // product, then dividend/quotient
   logic [REM_W-1:0]      rem_ff, rem_in;

   logic [FAC_W:0]        mul_sum;
   logic [DIV_W-1:0]      trial;
   logic [DIV_W-1:0]      trial_diff;
   logic                  q_bit;

   assign mul_sum    = {1'b0, p_ff[PROD_W-1:ELAPSED_HI_W]}
                     + (p_ff[0] ? {1'b0, fac_ff} : {(FAC_W+1){1'b0}});
   assign trial      = {rem_ff, p_ff[PROD_W-1]};
   assign q_bit      = (trial >= DIVISOR);
   assign trial_diff = trial - DIVISOR;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      fac_in   = fac_ff;
      p_in     = p_ff;
      rem_in   = rem_ff;
      case (state_ff)
         MS_IDLE: begin
            if (start) begin
               fac_in   = {8'b0, accel_rate} * {8'b0, cruise_duty};
               p_in     = {{FAC_W{1'b0}}, elapsed_new[ELAPSED_W-1:RAMP_SHIFT]};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = MS_MUL;
            end
         end
         MS_MUL: begin
            p_in   = {mul_sum, p_ff[ELAPSED_HI_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = MS_DIV;
            end
         end
         MS_DIV: begin
            rem_in = q_bit ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
            p_in   = {p_ff[PROD_W-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = MS_IDLE;
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      fac_ff <= fac_in;
      p_ff   <= p_in;
      rem_ff <= rem_in;
   end

   // sat is set once the quotient reaches the cruise duty
   assign done        = done_ff;
   assign result.sat  = (|p_ff[PROD_W-1:8]) || (p_ff[7:0] >= cruise_duty);
   assign result.duty = p_ff[7:0];

endmodule

`default_nettype wire

// ===== design/motor_ramp_stop_sequencer.sv =====
// Top level of the motor ramp/stop sequencer: registers, control and result word.
`default_nettype none

// Motor drive sequencer, advanced by one req word per PWM tick. Each word adds
// TICK_US to the microsecond timer and steps the phase machine (stopped, ramp,
// transit, stopping); exactly one rsp word comes back per req word, carrying
// duty, direction, drive enable and phase. In ramp the duty is
// ((timer >> 8) * accel rate * cruise duty) / RAMP_DIVISOR, saturated at the
// cruise duty, after which the run cruises in transit. Runs stop on low
// battery, on the track-end switch in the travel direction, on the optional
// timeout and on the optional distance target; stopping holds duty 0 for
// stop_delay_us. Start requests are latched until the block is stopped;
// test mode reverses automatically after timeout_us idle.
// One word at a time: a new req word is accepted only after the last one
// has committed its result, and a word takes longer while ramping. The
// 32-bit timer add and all limit compares run bit-serially; the ramp duty
// adds a shift-add multiply and a restoring divide. A held rsp word does
// not block the next req word, only the commit of its result.
// Configuration writes take effect at once and are meant for
// idle periods. Register indexes: 0 accel rate, 1 cruise duty, 2 stop_delay_us,
// 3 timeout_us, 4 battery floor, 5 distance_target, 6 options
// (bit0 test mode, bit1 timeout stop, bit2 distance stop).

module motor_ramp_stop_sequencer #(
   parameter int TICK_US      = 4080,
   parameter int RAMP_DIVISOR = 390625
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  mrss_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output mrss_pkg::rsp_type                  rsp_data,
   input  wire                                csr_we,
   input  wire  [mrss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [mrss_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mrss_pkg::*;

   // config registers
   logic [7:0]           accel_rate_ff;
   logic [7:0]           cruise_duty_ff;
   logic [ELAPSED_W-1:0] stop_delay_ff;
   logic [ELAPSED_W-1:0] timeout_ff;
   logic [9:0]           batt_floor_ff;
   logic [23:0]          distance_target_ff;
   logic [2:0]           options_ff;

   // sequencer state
   top_state_type        state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 direction_ff, direction_in;
   logic                 pend_fwd_ff, pend_fwd_in;
   logic                 pend_rev_ff, pend_rev_in;

   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic                 scan_start;
   logic                 math_start;
   logic                 commit;

   logic                 scan_done;
   logic [ELAPSED_W-1:0] scan_elapsed;
   scan_flags_type       flags;
   logic                 math_done;
   ramp_result_type      ramp_result;

   logic [7:0]           duty_val;
   logic                 enable_val;
   logic                 halt;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   //--------------------------------------------------------------------
   // Configuration writes
   //--------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_rate_ff      <= 8'd20;
         cruise_duty_ff     <= 8'd130;
         stop_delay_ff      <= 32'd2000000;
         timeout_ff         <= 32'd10000000;
         batt_floor_ff      <= 10'd704;
         distance_target_ff <= 24'd0;
         options_ff         <= 3'd3;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_RATE:      accel_rate_ff      <= csr_wdata[7:0];
            CSR_CRUISE_DUTY:     cruise_duty_ff     <= csr_wdata[7:0];
            CSR_STOP_DELAY_US:   stop_delay_ff      <= csr_wdata;
            CSR_TIMEOUT_US:      timeout_ff         <= csr_wdata;
            CSR_BATT_FLOOR:      batt_floor_ff      <= csr_wdata[9:0];
            CSR_DISTANCE_TARGET: distance_target_ff <= csr_wdata[23:0];
            CSR_OPTIONS:         options_ff         <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   //--------------------------------------------------------------------
   // Datapath units
   //--------------------------------------------------------------------
   mrss_serial_scan #(
      .TICK_US (TICK_US)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .start           (scan_start),
      .elapsed         (elapsed_ff),
      .stop_delay_us   (stop_delay_ff),
      .timeout_us      (timeout_ff),
      .position_count  (req_ff.position_count),
      .distance_target (distance_target_ff),
      .battery_level   (req_ff.battery_level),
      .batt_floor      (batt_floor_ff),
      .done            (scan_done),
      .elapsed_new     (scan_elapsed),
      .flags           (flags)
   );

   mrss_ramp_math #(
      .RAMP_DIVISOR (RAMP_DIVISOR)
   ) u_math (
      .clock       (clock),
      .reset       (reset),
      .start       (math_start),
      .elapsed_new (scan_elapsed),
      .accel_rate  (accel_rate_ff),
      .cruise_duty (cruise_duty_ff),
      .done        (math_done),
      .result      (ramp_result)
   );

   //--------------------------------------------------------------------
   // Control: idle -> serial scan -> (ramp math) -> commit
   //--------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      scan_start = 1'b0;
      math_start = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (phase_ff == PH_RAMP) begin
                  math_start = 1'b1;
                  state_in   = ST_MATH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MATH: begin
            if (math_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // result register must be free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   //--------------------------------------------------------------------
   // Tick decision: phase action, stop rules, start rules
   //--------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = scan_elapsed;
      direction_in = direction_ff;
      pend_fwd_in  = pend_fwd_ff | req_ff.request_forward;
      pend_rev_in  = pend_rev_ff | req_ff.request_reverse;
      duty_val     = 8'd0;
      enable_val   = 1'b1;
      halt         = 1'b0;

      case (phase_ff)
         PH_STOPPED: begin
            enable_val = 1'b0;
         end
         PH_RAMP: begin
            if (ramp_result.sat) begin
               duty_val = cruise_duty_ff;
               phase_in = PH_TRANSIT;
            end else begin
               duty_val = ramp_result.duty;
            end
         end
         PH_STOPPING: begin
            if (flags.ge_stop) begin
               phase_in = PH_STOPPED;
            end
         end
         PH_TRANSIT: begin
            duty_val = cruise_duty_ff;
         end
         default: ;
      endcase

      // stop rules while running
      if (phase_in == PH_RAMP || phase_in == PH_TRANSIT) begin
         halt = flags.batt_under
              | (direction_ff & req_ff.at_track_end)
              | (~direction_ff & req_ff.at_track_start)
              | (options_ff[OPT_TIMEOUT_STOP] & flags.ge_timeout)
              | (options_ff[OPT_DISTANCE_STOP]
                 & (direction_ff ? flags.target_lt_pos : flags.pos_lt_target));
         if (halt) begin
            elapsed_in = '0;
            duty_val   = 8'd0;
            phase_in   = PH_STOPPING;
         end
      end

      // start rules when stopped; later starts win
      if (phase_in == PH_STOPPED) begin
         if (options_ff[OPT_TEST_MODE]) begin
            if (flags.ge_timeout) begin
               if (direction_ff) begin
                  pend_rev_in = 1'b1;
               end else begin
                  pend_fwd_in = 1'b1;
               end
               elapsed_in = '0;
            end
            if (req_ff.at_track_end) begin
               direction_in = 1'b0;
               elapsed_in   = '0;
               phase_in     = PH_RAMP;
               enable_val   = 1'b1;
               duty_val     = 8'd0;
            end
            if (req_ff.at_track_start) begin
               direction_in = 1'b1;
               elapsed_in   = '0;
               phase_in     = PH_RAMP;
               enable_val   = 1'b1;
               duty_val     = 8'd0;
            end
         end
         if (pend_fwd_in) begin
            pend_fwd_in  = 1'b0;
            direction_in = 1'b1;
            elapsed_in   = '0;
            phase_in     = PH_RAMP;
            enable_val   = 1'b1;
            duty_val     = 8'd0;
         end
         if (pend_rev_in) begin
            pend_rev_in  = 1'b0;
            direction_in = 1'b0;
            elapsed_in   = '0;
            phase_in     = PH_RAMP;
            enable_val   = 1'b1;
            duty_val     = 8'd0;
         end
      end

      rsp_in.duty         = duty_val;
      rsp_in.forward      = direction_in;
      rsp_in.drive_enable = enable_val;
      rsp_in.phase        = phase_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_STOPPED;
         elapsed_ff   <= '0;
         direction_ff <= 1'b0;
         pend_fwd_ff  <= 1'b0;
         pend_rev_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            phase_ff     <= phase_in;
            elapsed_ff   <= elapsed_in;
            direction_ff <= direction_in;
            pend_fwd_ff  <= pend_fwd_in;
            pend_rev_ff  <= pend_rev_in;
         end
      end
      if (accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   //--------------------------------------------------------------------
   // Checks
   //--------------------------------------------------------------------
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted word did not start the scan");

   a_math_only_in_math: assert property (@(posedge clock) disable iff (reset)
      math_done |-> state_ff == ST_MATH)
      else $error("ramp math finished outside the math state");

   a_running_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase != PH_STOPPED |-> rsp_data.drive_enable)
      else $error("drive disabled while not stopped");

   a_idle_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.phase == PH_STOPPED || rsp_data.phase == PH_STOPPING)
      |-> rsp_data.duty == 8'd0)
      else $error("nonzero duty while stopped or stopping");

endmodule

`default_nettype wire

// ===== verif/motor_ramp_stop_sequencer_tb.sv =====
// Self-checking testbench for the motor ramp/stop sequencer.
`timescale 1ns / 1ps

// Test plan
// - Every accepted req word steps a behavioral copy of the drive sequencer
//   (phase, run timer, direction, latched start requests). The expected rsp
//   word is queued at that point.
// - The checker pops the oldest expected word for every rsp handshake and
//   compares duty, direction, drive enable and phase.
// - Directed runs come first. They cover the reset settings, start and stop
//   rules, both request latches, the distance limits on each side, the
//   test-mode auto-reverse, zero cruise duty, conflicting starts in one tick,
//   stop delay and timeout at their extremes, and the first stopped tick
//   that still drives the PWM.
// - Random runs follow under several register settings. Most ticks are
//   clean (healthy battery, position on the safe side), so runs get through
//   the ramp into cruise. Switch hits, battery dips and off-target positions
//   come as noise whose rate depends on the phase.
// - The sender idles in bursts. The receiver stalls on its own changing
//   pattern, and once it holds off for a long stretch so the block backs up.
// - Registers are only rewritten when no rsp word is still outstanding.
module motor_ramp_stop_sequencer_tb;
   import mrss_pkg::*;

   localparam int          TICK_US          = 4080;
   localparam int          RAMP_DIVISOR     = 390625;
   localparam int unsigned RUN_LIMIT_CYCLES = 2000000;
   localparam int unsigned HOLDOFF_CYCLES   = 700;
   localparam int unsigned TAIL_CYCLES      = 120;   // a little over one ramping tick
   localparam int unsigned RANDOM_PHASES    = 10;
   localparam int unsigned WORDS_PER_PHASE  = 135;

   // Register image, the same fields the csr port writes
   typedef struct packed {
      logic [7:0]  accel_rate;
      logic [7:0]  cruise_duty;
      logic [31:0] stop_delay_us;
      logic [31:0] timeout_us;
      logic [9:0]  batt_floor;
      logic [23:0] distance_target;
      logic [2:0]  options;
   } drive_cfg_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Sequencer copy used for prediction
   drive_cfg_type cfg_now;
   phase_type     sim_phase;
   logic [31:0]   run_timer_us;
   logic          run_forward;
   logic          want_forward;
   logic          want_reverse;
   logic [7:0]    last_duty;
   logic          last_enable;

   rsp_type       expected_drive_q[$];

   int unsigned   words_sent;
   int unsigned   words_checked;
   int unsigned   mismatch_count;
   int unsigned   cfg_writes;
   int unsigned   runs_started;
   int unsigned   cruise_reached;
   int unsigned   stops_taken;
   int unsigned   cycles_run;
   int unsigned   burst_left;
   int unsigned   glitch_odds;   // 1 in N ticks carries noise
   bit            steady_send;   // no sender gaps while set
   int unsigned   holdoff_asked = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   motor_ramp_stop_sequencer #(
      .TICK_US      (TICK_US),
      .RAMP_DIVISOR (RAMP_DIVISOR)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic void begin_run(input logic fwd);
      run_forward  = fwd;
      run_timer_us = '0;
      sim_phase    = PH_RAMP;
      last_enable  = 1'b1;
      last_duty    = '0;
      runs_started++;
   endfunction

   // One PWM tick: latch requests, advance the timer, step the phase, then
   // stop rules (running phases) and start rules (stopped phase).
   function automatic rsp_type next_drive_word(input req_type w);
      logic [63:0] ramp_q;
      logic        stop_now;
      logic        past_target;
      rsp_type     r;
      want_forward = want_forward | w.request_forward;
      want_reverse = want_reverse | w.request_reverse;
      run_timer_us = run_timer_us + TICK_US;
      last_enable  = 1'b1;
      case (sim_phase)
         PH_STOPPED: begin
            last_enable = 1'b0;
            last_duty   = '0;
         end
         PH_RAMP: begin
            // full-width product, no wrap before the divide
            ramp_q = {40'd0, run_timer_us[31:8]};
            ramp_q = ramp_q * cfg_now.accel_rate * cfg_now.cruise_duty / RAMP_DIVISOR;
            if (ramp_q >= cfg_now.cruise_duty) begin
               last_duty = cfg_now.cruise_duty;
               sim_phase = PH_TRANSIT;
               cruise_reached++;
            end else begin
               last_duty = ramp_q[7:0];
            end
         end
         PH_STOPPING: begin
            last_duty = '0;
            if (run_timer_us >= cfg_now.stop_delay_us) sim_phase = PH_STOPPED;
         end
         default: last_duty = cfg_now.cruise_duty;
      endcase

      if (sim_phase == PH_RAMP || sim_phase == PH_TRANSIT) begin
         past_target = run_forward ? (cfg_now.distance_target < w.position_count)
                                   : (w.position_count < cfg_now.distance_target);
         stop_now = (w.battery_level < cfg_now.batt_floor)
                 || (run_forward && w.at_track_end)
                 || (!run_forward && w.at_track_start)
                 || (cfg_now.options[OPT_TIMEOUT_STOP]
                     && run_timer_us >= cfg_now.timeout_us)
                 || (cfg_now.options[OPT_DISTANCE_STOP] && past_target);
         if (stop_now) begin
            run_timer_us = '0;
            last_duty    = '0;
            sim_phase    = PH_STOPPING;
            stops_taken++;
         end
      end

      // later starts win: track end, track start, forward, reverse
      if (sim_phase == PH_STOPPED) begin
         if (cfg_now.options[OPT_TEST_MODE]) begin
            if (run_timer_us >= cfg_now.timeout_us) begin
               if (run_forward) want_reverse = 1'b1;
               else             want_forward = 1'b1;
               run_timer_us = '0;
            end
            if (w.at_track_end)   begin_run(1'b0);
            if (w.at_track_start) begin_run(1'b1);
         end
         if (want_forward) begin
            want_forward = 1'b0;
            begin_run(1'b1);
         end
         if (want_reverse) begin
            want_reverse = 1'b0;
            begin_run(1'b0);
         end
      end

      r.duty         = last_duty;
      r.forward      = run_forward;
      r.drive_enable = last_enable;
      r.phase        = sim_phase;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type tick_word(input logic rf, input logic rr, input logic ts,
                                         input logic te, input logic [9:0] batt,
                                         input logic [23:0] pos);
      req_type w;
      w.request_forward = rf;
      w.request_reverse = rr;
      w.at_track_start  = ts;
      w.at_track_end    = te;
      w.battery_level   = batt;
      w.position_count  = pos;
      return w;
   endfunction

   // Mostly a clean tick for the current run; noise at 1 in glitch_odds.
   function automatic req_type random_tick_word();
      req_type     w;
      logic [23:0] tgt;
      tgt = cfg_now.distance_target;
      w.request_forward = ($urandom_range(0, 11) == 0);
      w.request_reverse = ($urandom_range(0, 11) == 0);
      w.at_track_start  = ($urandom_range(0, glitch_odds) == 0);
      w.at_track_end    = ($urandom_range(0, glitch_odds) == 0);
      if ($urandom_range(0, glitch_odds) == 0)
         w.battery_level = 10'($urandom_range(0, 1023));
      else
         w.battery_level = 10'($urandom_range(cfg_now.batt_floor, 1023));
      if ($urandom_range(0, glitch_odds) == 0) begin
         if ($urandom_range(0, 1) == 0) w.position_count = 24'($urandom);
         else w.position_count = tgt + 24'($urandom_range(0, 2)) - 24'd1;
      end else if ($urandom_range(0, 3) == 0) begin
         w.position_count = tgt;   // on the limit, still allowed
      end else if (run_forward) begin
         w.position_count = 24'($urandom_range(0, tgt));
      end else begin
         w.position_count = 24'($urandom_range(tgt, 24'hFFFFFF));
      end
      return w;
   endfunction

   function automatic drive_cfg_type random_drive_cfg(input int unsigned phase_no);
      drive_cfg_type c;
      // accel rate sets the ramp length: about 24500 / rate ticks
      c.accel_rate = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(170, 255));
      c.cruise_duty = 8'($urandom);
      if ($urandom_range(0, 5) == 0) c.cruise_duty = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      c.stop_delay_us = $urandom_range(0, 40000);
      c.timeout_us = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60000)
                                                 : $urandom_range(300000, 900000);
      c.batt_floor      = 10'($urandom);
      c.distance_target = 24'($urandom);
      c.options         = 3'($urandom);
      case (phase_no)
         0: begin   // long clean cruise
            c.accel_rate  = 8'd255;
            c.cruise_duty = 8'd255;
            c.timeout_us  = 32'hFFFF_FFFF;
            c.options     = 3'b000;
         end
         1: c.accel_rate = 8'd0;   // never leaves the ramp by itself unless cruise duty is 0
         default: ;
      endcase
      return c;
   endfunction

   task automatic put_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // All seven registers, one per cycle; only called with the block idle.
   task automatic write_drive_cfg(input drive_cfg_type c);
      put_csr(CSR_ACCEL_RATE,      {24'd0, c.accel_rate});
      put_csr(CSR_CRUISE_DUTY,     {24'd0, c.cruise_duty});
      put_csr(CSR_STOP_DELAY_US,   c.stop_delay_us);
      put_csr(CSR_TIMEOUT_US,      c.timeout_us);
      put_csr(CSR_BATT_FLOOR,      {22'd0, c.batt_floor});
      put_csr(CSR_DISTANCE_TARGET, {8'd0, c.distance_target});
      put_csr(CSR_OPTIONS,         {29'd0, c.options});
      csr_we  <= 1'b0;
      cfg_now = c;
      cfg_writes++;
   endtask

   // Sends one tick word and leaves valid high. The caller either sends again
   // in the same step or drops valid (settle_block).
   task automatic send_tick(input req_type w);
      int unsigned gap;
      if (!steady_send && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 140) : $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      expected_drive_q.push_back(next_drive_word(w));
      words_sent++;
   endtask

   // Drop valid and wait for every outstanding rsp word.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: idle, forward start, a slow ramp tick, low battery stop.
   task automatic test_reset_runs();
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h000000));
      send_tick(tick_word(1, 0, 0, 0, 10'd1023, 24'h000000));
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h000000));
      send_tick(tick_word(0, 0, 0, 0, 10'd0,    24'h000000));
      settle_block();
   endtask

   // Distance stop on each side; both requests in one tick, reverse wins.
   task automatic test_direction_and_distance();
      drive_cfg_type c;
      c = '{accel_rate: 8'd255, cruise_duty: 8'd255, stop_delay_us: 32'd0,
            timeout_us: 32'hFFFF_FFFF, batt_floor: 10'd0,
            distance_target: 24'h800000, options: 3'b100};
      write_drive_cfg(c);
      // stopping -> stopped, PWM still connected on this tick
      send_tick(tick_word(0, 0, 0, 0, 10'd0,    24'h000000));
      send_tick(tick_word(0, 0, 0, 0, 10'd0,    24'h000000));
      send_tick(tick_word(1, 1, 0, 0, 10'd1023, 24'h7FFFFF));
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h800000));
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h7FFFFF));
      // switches ignored outside test mode, latched forward starts
      send_tick(tick_word(1, 0, 1, 1, 10'd1023, 24'hFFFFFF));
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'hFFFFFF));
      settle_block();
   endtask

   // Test-mode auto-reverse at zero timeout, zero cruise duty, every start
   // source in one tick, several stop rules at once.
   task automatic test_auto_reverse_and_zero_speed();
      drive_cfg_type c;
      c = '{accel_rate: 8'd0, cruise_duty: 8'd0, stop_delay_us: 32'd0,
            timeout_us: 32'd0, batt_floor: 10'd1023,
            distance_target: 24'hFFFFFF, options: 3'b001};
      write_drive_cfg(c);
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h000000));
      send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h000000));
      send_tick(tick_word(0, 0, 0, 0, 10'd1022, 24'h000000));
      send_tick(tick_word(1, 1, 1, 1, 10'd1023, 24'h000000));
      send_tick(tick_word(0, 0, 1, 1, 10'd0,    24'h000000));
      settle_block();
   endtask

   // Longest stop delay holds the stop, then a short timeout ends a ramp.
   task automatic test_stop_delay_and_timeout();
      drive_cfg_type c;
      c = '{accel_rate: 8'd255, cruise_duty: 8'd255, stop_delay_us: 32'hFFFF_FFFF,
            timeout_us: 32'd12240, batt_floor: 10'd0,
            distance_target: 24'h000000, options: 3'b010};
      write_drive_cfg(c);
      send_tick(tick_word(0, 0, 0, 0, 10'd512, 24'h000000));
      send_tick(tick_word(1, 0, 0, 0, 10'd512, 24'h000000));
      settle_block();
      c.stop_delay_us = 32'd0;
      write_drive_cfg(c);
      repeat (4) send_tick(tick_word(0, 0, 0, 0, 10'd1023, 24'h000000));
      settle_block();
   endtask

   task automatic test_random_runs(input int unsigned first_phase, input int unsigned phases);
      for (int unsigned p = first_phase; p < first_phase + phases; p++) begin
         settle_block();
         write_drive_cfg(random_drive_cfg(p));
         glitch_odds = (p % 2 == 0) ? 300 : 15;
         for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) send_tick(random_tick_word());
      end
   endtask

   // Receiver holds off while words keep coming, so req_ready must drop.
   task automatic test_output_backpressure();
      holdoff_asked <= holdoff_asked + 1;
      steady_send = 1'b1;
      repeat (8) send_tick(random_tick_word());
      steady_send = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: own stall pattern plus the requested long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int unsigned stall_left;
      int unsigned mode_left;
      int unsigned mode;
      int unsigned holdoff_seen;
      int unsigned beat;
      logic        open_now;
      stall_left   = 0;
      mode_left    = 0;
      mode         = 0;
      holdoff_seen = 0;
      beat         = 0;
      forever begin
         @(posedge clock);
         beat++;
         if (holdoff_seen != holdoff_asked) begin
            holdoff_seen = holdoff_asked;
            stall_left   = HOLDOFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         case (mode)
            0: open_now = 1'b1;
            1: open_now = ($urandom_range(0, 1) == 1);
            2: open_now = ((beat % 9) < 6);
            default: begin
               if (stall_left == 0 && $urandom_range(0, 40) == 0)
                  stall_left = $urandom_range(1, 150);
               open_now = 1'b1;
            end
         endcase
         rsp_ready <= open_now && (stall_left == 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // ---------------------------------------------------------------------
   // Result check against the oldest expected word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_word_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("[%0t] unexpected rsp word: duty %0d fwd %0d en %0d phase %0d",
                        $time, rsp_data.duty, rsp_data.forward, rsp_data.drive_enable,
                        rsp_data.phase);
            mismatch_count++;
         end else begin
            want = expected_drive_q.pop_front();
            words_checked++;
            if (rsp_data.duty !== want.duty || rsp_data.forward !== want.forward
                || rsp_data.drive_enable !== want.drive_enable
                || rsp_data.phase !== want.phase) begin
               if (mismatch_count < 10)
                  $display("[%0t] word %0d duty/fwd/en/phase: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           $time, words_checked, want.duty, want.forward,
                           want.drive_enable, want.phase, rsp_data.duty, rsp_data.forward,
                           rsp_data.drive_enable, rsp_data.phase);
               mismatch_count++;
            end
         end
      end
   end

   // Hang guard
   initial begin : watchdog
      for (cycles_run = 0; cycles_run < RUN_LIMIT_CYCLES; cycles_run++) @(posedge clock);
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycles_run, expected_drive_q.size());
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      // reset values of the sequencer copy
      cfg_now = '{accel_rate: 8'd20, cruise_duty: 8'd130, stop_delay_us: 32'd2000000,
                  timeout_us: 32'd10000000, batt_floor: 10'd704,
                  distance_target: 24'd0, options: 3'b011};
      sim_phase      = PH_STOPPED;
      run_timer_us   = '0;
      run_forward    = 1'b0;
      want_forward   = 1'b0;
      want_reverse   = 1'b0;
      last_duty      = '0;
      last_enable    = 1'b0;
      words_sent     = 0;
      words_checked  = 0;
      mismatch_count = 0;
      cfg_writes     = 0;
      runs_started   = 0;
      cruise_reached = 0;
      stops_taken    = 0;
      burst_left     = 0;
      glitch_odds    = 300;
      steady_send    = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_runs();
      test_direction_and_distance();
      test_auto_reverse_and_zero_speed();
      test_stop_delay_and_timeout();
      test_random_runs(0, RANDOM_PHASES / 2);
      test_output_backpressure();
      test_random_runs(RANDOM_PHASES / 2, RANDOM_PHASES - RANDOM_PHASES / 2);

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Tick words: %0d sent, %0d checked, under %0d register settings.",
               words_sent, words_checked, cfg_writes + 1);
      $display("Runs started %0d, cruise reached %0d, stops %0d, in %0d cycles.",
               runs_started, cruise_reached, stops_taken, cycles_run);
      if (mismatch_count == 0 && expected_drive_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d words never arrived",
                  mismatch_count, expected_drive_q.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
